// ----- rtl/windowed_pc_stride_prefetcher_unit_defines.svh -----
// assertion macros shared by the prefetcher rtl
// no dependencies; included by the files that carry assertions
`ifndef WINDOWED_PC_STRIDE_PREFETCHER_UNIT_DEFINES_SVH
`define WINDOWED_PC_STRIDE_PREFETCHER_UNIT_DEFINES_SVH

// same-cycle implication
`define WPSP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WPSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/wpsp_pkg.sv -----
// constants, types and state codes of the windowed pc stride prefetcher
// no dependencies; imported by every rtl module of the block except wpsp_ram
`default_nettype none

package wpsp_pkg;

    localparam int WINDOW_DEPTH = 10;
    localparam int TABLE_DEPTH  = 256;
    localparam int ADDR_BITS    = 32;
    localparam int PC_BITS      = 32;

    localparam int LIMIT_BITS   = ADDR_BITS + 1;
    localparam int STRIDE_BITS  = ADDR_BITS + 1;
    localparam int TARGET_BITS  = ADDR_BITS + 2;

    localparam int WIN_POS_BITS = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    localparam int TBL_LANES     = 8;
    localparam int TBL_LANE_BITS = $clog2(TBL_LANES);
    localparam int TBL_ROWS      = (TABLE_DEPTH + TBL_LANES - 1) / TBL_LANES;
    localparam int TBL_ROW_BITS  = (TBL_ROWS > 1) ? $clog2(TBL_ROWS) : 1;
    localparam int TBL_SLOT_BITS = TBL_ROW_BITS + TBL_LANE_BITS;

    localparam int JOB_QUEUE_DEPTH = 2;
    localparam int JOB_PTR_BITS    = (JOB_QUEUE_DEPTH > 1) ? $clog2(JOB_QUEUE_DEPTH) : 1;
    localparam int JOB_CNT_BITS    = $clog2(JOB_QUEUE_DEPTH + 1);

    localparam logic [LIMIT_BITS-1:0] MEM_LIMIT_RESET = {1'b1, {ADDR_BITS{1'b0}}};

    typedef struct packed {
        logic [PC_BITS-1:0]     pc;
        logic [ADDR_BITS-1:0]   addr;
        logic                   upd;
        logic [PC_BITS-1:0]     old_pc;
        logic [STRIDE_BITS-1:0] stride;
    } t_job;

    typedef struct packed {
        logic [PC_BITS-1:0]     pc;
        logic [STRIDE_BITS-1:0] stride;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_APPLY,
        BK_CHECK
    } t_back_state;

endpackage

`default_nettype wire

// ----- rtl/wpsp_ram.sv -----
// generic single write port ram with registered read
// no dependencies; holds one lane of the pc table
`default_nettype none

module wpsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  wire logic [WIDTH-1:0]                              i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                                   o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/wpsp_front.sv -----
// front end: access window ring, stride derivation, job generation
// depends on wpsp_pkg and the assertion macro header
`default_nettype none
`include "windowed_pc_stride_prefetcher_unit_defines.svh"

module wpsp_front
    import wpsp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_access_valid,
    output logic                      o_access_ready,
    input  wire logic [PC_BITS-1:0]   i_access_pc,
    input  wire logic [ADDR_BITS-1:0] i_access_addr,
    output logic                      o_job_valid,
    input  wire logic                 i_job_ready,
    output t_job                      o_job
);

    localparam logic [WIN_POS_BITS-1:0] WIN_LAST = WIN_POS_BITS'(WINDOW_DEPTH - 1);

    logic [PC_BITS-1:0]      r_win_pc   [WINDOW_DEPTH];
    logic [ADDR_BITS-1:0]    r_win_addr [WINDOW_DEPTH];
    logic [WIN_POS_BITS-1:0] r_pos;
    logic [WIN_POS_BITS-1:0] n_pos;
    logic                    r_full;
    logic                    w_acc;
    logic [PC_BITS-1:0]      w_old_pc;
    logic [ADDR_BITS-1:0]    w_old_addr;

    assign w_acc          = i_access_valid && i_job_ready;
    assign o_access_ready = i_job_ready;
    assign o_job_valid    = i_access_valid;

    assign w_old_pc   = r_win_pc[r_pos];
    assign w_old_addr = r_win_addr[r_pos];
    assign n_pos      = (r_pos == WIN_LAST) ? '0 : r_pos + 1'b1;

    always_comb begin
        o_job.pc     = i_access_pc;
        o_job.addr   = i_access_addr;
        o_job.upd    = r_full;
        o_job.old_pc = w_old_pc;
        o_job.stride = {1'b0, i_access_addr} - {1'b0, w_old_addr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_full <= 1'b0;
        end else if (w_acc) begin
            r_pos <= n_pos;
            if (r_pos == WIN_LAST) begin
                r_full <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_win_pc[r_pos]   <= i_access_pc;
            r_win_addr[r_pos] <= i_access_addr;
        end
    end

    `WPSP_ASSERT_NEXT(a_full_after_wrap, i_clk, i_rst_n, w_acc && (r_pos == WIN_LAST), r_full, "window not full after wrap")
    `WPSP_ASSERT_NEXT(a_full_sticks, i_clk, i_rst_n, r_full, r_full && (r_pos <= WIN_LAST), "window full flag dropped")
    `WPSP_ASSERT_NEXT(a_pos_holds, i_clk, i_rst_n, !w_acc, $stable(r_pos), "window position moved without a transaction")

endmodule

`default_nettype wire

// ----- rtl/wpsp_fifo.sv -----
// short job queue between the front end and the table engine
// depends on wpsp_pkg and the assertion macro header
`default_nettype none
`include "windowed_pc_stride_prefetcher_unit_defines.svh"

module wpsp_fifo
    import wpsp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push_valid,
    output logic      o_push_ready,
    input  wire t_job i_push_job,
    output logic      o_pop_valid,
    input  wire logic i_pop_ready,
    output t_job      o_pop_job
);

    localparam logic [JOB_PTR_BITS-1:0] PTR_LAST = JOB_PTR_BITS'(JOB_QUEUE_DEPTH - 1);
    localparam logic [JOB_CNT_BITS-1:0] CNT_FULL = JOB_CNT_BITS'(JOB_QUEUE_DEPTH);

    t_job                    r_mem [JOB_QUEUE_DEPTH];
    logic [JOB_PTR_BITS-1:0] r_wr;
    logic [JOB_PTR_BITS-1:0] r_rd;
    logic [JOB_CNT_BITS-1:0] r_cnt;
    logic                    w_push;
    logic                    w_pop;

    assign o_push_ready = (r_cnt != CNT_FULL);
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_job    = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

    `WPSP_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_FULL, "queue count out of range")

endmodule

`default_nettype wire

// ----- rtl/wpsp_back.sv -----
// table engine: lane-parallel pc table scan, stride update, prefetch check
// depends on wpsp_pkg, wpsp_ram and the assertion macro header
`default_nettype none
`include "windowed_pc_stride_prefetcher_unit_defines.svh"

module wpsp_back
    import wpsp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_job_valid,
    output logic                       o_job_ready,
    input  wire t_job                  i_job,
    input  wire logic                  i_cfg_valid,
    input  wire logic [LIMIT_BITS-1:0] i_cfg_mem_limit,
    output logic                       o_prefetch_valid,
    input  wire logic                  i_prefetch_ready,
    output logic [ADDR_BITS-1:0]       o_prefetch_addr
);

    localparam logic [TBL_ROW_BITS:0]    ROW_END   = (TBL_ROW_BITS + 1)'(TBL_ROWS);
    localparam logic [TBL_ROW_BITS-1:0]  ROW_LAST  = TBL_ROW_BITS'(TBL_ROWS - 1);
    localparam logic [TBL_SLOT_BITS:0]   SLOT_END  = (TBL_SLOT_BITS + 1)'(TABLE_DEPTH);
    localparam logic [TBL_SLOT_BITS-1:0] SLOT_LAST = TBL_SLOT_BITS'(TABLE_DEPTH - 1);

    t_back_state r_state;
    t_back_state n_state;

    t_job                     r_job;
    logic [TBL_ROW_BITS:0]    r_row;
    logic                     r_cmp_vld;
    logic [TBL_ROW_BITS-1:0]  r_cmp_row;
    logic                     r_upd_found;
    logic [TBL_SLOT_BITS-1:0] r_upd_slot;
    logic                     r_h1_found;
    logic [TBL_SLOT_BITS-1:0] r_h1_slot;
    logic [STRIDE_BITS-1:0]   r_h1_stride;
    logic                     r_h2_found;
    logic [STRIDE_BITS-1:0]   r_h2_stride;
    logic [TBL_SLOT_BITS-1:0] r_ins_pos;
    logic [TBL_LANES-1:0]     r_valid [TBL_ROWS];
    logic                     r_hit;
    logic [STRIDE_BITS-1:0]   r_hit_stride;
    logic [LIMIT_BITS-1:0]    r_limit;
    logic                     r_out_valid;
    logic [ADDR_BITS-1:0]     r_out_addr;

    logic                     n_upd_found;
    logic [TBL_SLOT_BITS-1:0] n_upd_slot;
    logic                     n_h1_found;
    logic [TBL_SLOT_BITS-1:0] n_h1_slot;
    logic [STRIDE_BITS-1:0]   n_h1_stride;
    logic                     n_h2_found;
    logic [STRIDE_BITS-1:0]   n_h2_stride;
    logic                     n_hit;
    logic [STRIDE_BITS-1:0]   n_hit_stride;

    logic                     w_pop;
    logic                     w_issue;
    logic                     w_apply;
    logic                     w_load;
    logic                     w_check_done;
    logic                     w_load_ok;
    logic                     w_in_range;
    logic [TARGET_BITS-1:0]   w_target;

    t_entry                   w_rdata   [TBL_LANES];
    logic [STRIDE_BITS-1:0]   w_lstride [TBL_LANES];
    logic [TBL_LANES-1:0]     w_upd_m;
    logic [TBL_LANES-1:0]     w_hit_m;
    logic                     w_row_upd_f;
    logic [TBL_LANE_BITS-1:0] w_row_upd_lane;
    logic                     w_row_h1_f;
    logic [TBL_LANE_BITS-1:0] w_row_h1_lane;
    logic                     w_row_h2_f;
    logic [TBL_LANE_BITS-1:0] w_row_h2_lane;

    logic                     w_ins;
    logic [TBL_SLOT_BITS-1:0] w_wslot;
    logic [TBL_ROW_BITS-1:0]  w_wrow;
    logic [TBL_LANE_BITS-1:0] w_wlane;
    logic [TBL_LANES-1:0]     w_we;
    t_entry                   w_wentry;
    logic [TBL_ROW_BITS-1:0]  w_rrow;

    // table lanes
    assign w_rrow          = r_row[TBL_ROW_BITS-1:0];
    assign w_wrow          = w_wslot[TBL_SLOT_BITS-1:TBL_LANE_BITS];
    assign w_wlane         = w_wslot[TBL_LANE_BITS-1:0];
    assign w_wentry.pc     = r_job.old_pc;
    assign w_wentry.stride = r_job.stride;

    for (genvar g = 0; g < TBL_LANES; g++) begin : g_lane
        wpsp_ram #(
            .WIDTH (ENTRY_BITS),
            .DEPTH (TBL_ROWS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we[g]),
            .i_waddr (w_wrow),
            .i_wdata (w_wentry),
            .i_raddr (w_rrow),
            .o_rdata (w_rdata[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    n_state = BK_SCAN;
                end
            end
            BK_SCAN: begin
                if (r_cmp_vld && (r_cmp_row == ROW_LAST)) begin
                    n_state = BK_APPLY;
                end
            end
            BK_APPLY: begin
                n_state = BK_CHECK;
            end
            BK_CHECK: begin
                if (w_check_done) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_job_ready  = 1'b0;
        w_issue      = 1'b0;
        w_apply      = 1'b0;
        w_check_done = 1'b0;
        w_load       = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                o_job_ready = 1'b1;
            end
            BK_SCAN: begin
                w_issue = (r_row < ROW_END);
            end
            BK_APPLY: begin
                w_apply = 1'b1;
            end
            BK_CHECK: begin
                w_check_done = !w_in_range || w_load_ok;
                w_load       = w_in_range && w_load_ok;
            end
            default: begin
                o_job_ready = 1'b0;
            end
        endcase
    end

    assign w_pop     = o_job_ready && i_job_valid;
    assign w_load_ok = !r_out_valid || i_prefetch_ready;

    // lane compare of the returned row
    always_comb begin
        t_entry e;
        logic   in_tbl;
        w_upd_m = '0;
        w_hit_m = '0;
        for (int l = 0; l < TBL_LANES; l++) begin
            in_tbl = ({1'b0, r_cmp_row, TBL_LANE_BITS'(l)} < SLOT_END);
            e      = r_valid[r_cmp_row][l] ? w_rdata[l] : '0;
            w_lstride[l] = e.stride;
            w_upd_m[l]   = in_tbl && (e.pc == r_job.old_pc);
            w_hit_m[l]   = in_tbl && (e.pc == r_job.pc);
        end
    end

    // lowest matches within the row
    always_comb begin
        w_row_upd_f    = 1'b0;
        w_row_upd_lane = '0;
        w_row_h1_f     = 1'b0;
        w_row_h1_lane  = '0;
        w_row_h2_f     = 1'b0;
        w_row_h2_lane  = '0;
        for (int l = 0; l < TBL_LANES; l++) begin
            if (w_upd_m[l] && !w_row_upd_f) begin
                w_row_upd_f    = 1'b1;
                w_row_upd_lane = TBL_LANE_BITS'(l);
            end
            if (w_hit_m[l] && w_row_h1_f && !w_row_h2_f) begin
                w_row_h2_f    = 1'b1;
                w_row_h2_lane = TBL_LANE_BITS'(l);
            end
            if (w_hit_m[l] && !w_row_h1_f) begin
                w_row_h1_f    = 1'b1;
                w_row_h1_lane = TBL_LANE_BITS'(l);
            end
        end
    end

    // merge row results into the running search
    always_comb begin
        n_upd_found = r_upd_found;
        n_upd_slot  = r_upd_slot;
        n_h1_found  = r_h1_found;
        n_h1_slot   = r_h1_slot;
        n_h1_stride = r_h1_stride;
        n_h2_found  = r_h2_found;
        n_h2_stride = r_h2_stride;
        if (r_cmp_vld) begin
            if (!r_upd_found && w_row_upd_f) begin
                n_upd_found = 1'b1;
                n_upd_slot  = {r_cmp_row, w_row_upd_lane};
            end
            priority if (!r_h1_found) begin
                if (w_row_h1_f) begin
                    n_h1_found  = 1'b1;
                    n_h1_slot   = {r_cmp_row, w_row_h1_lane};
                    n_h1_stride = w_lstride[w_row_h1_lane];
                end
                if (w_row_h2_f) begin
                    n_h2_found  = 1'b1;
                    n_h2_stride = w_lstride[w_row_h2_lane];
                end
            end else if (!r_h2_found && w_row_h1_f) begin
                n_h2_found  = 1'b1;
                n_h2_stride = w_lstride[w_row_h1_lane];
            end else begin
                n_h2_found = r_h2_found;
            end
        end
    end

    // table write and post-update lookup
    assign w_ins   = r_job.upd && !r_upd_found;
    assign w_wslot = r_upd_found ? r_upd_slot : r_ins_pos;

    always_comb begin
        w_we = '0;
        if (w_apply && r_job.upd) begin
            w_we[w_wlane] = 1'b1;
        end
    end

    always_comb begin
        priority if (!r_job.upd) begin
            n_hit        = r_h1_found;
            n_hit_stride = r_h1_stride;
        end else if (r_upd_found) begin
            n_hit        = r_h1_found;
            n_hit_stride = (r_h1_slot == r_upd_slot) ? r_job.stride : r_h1_stride;
        end else if (r_job.old_pc == r_job.pc) begin
            n_hit        = 1'b1;
            n_hit_stride = r_job.stride;
        end else if (r_h1_found && (r_h1_slot == r_ins_pos)) begin
            n_hit        = r_h2_found;
            n_hit_stride = r_h2_stride;
        end else begin
            n_hit        = r_h1_found;
            n_hit_stride = r_h1_stride;
        end
    end

    // range check
    assign w_target   = {2'b00, r_job.addr}
                        + {r_hit_stride[STRIDE_BITS-1], r_hit_stride};
    assign w_in_range = r_hit && !w_target[TARGET_BITS-1] && !w_target[ADDR_BITS]
                        && ({1'b0, w_target[ADDR_BITS-1:0]} < r_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_cmp_vld   <= 1'b0;
            r_ins_pos   <= '0;
            r_limit     <= MEM_LIMIT_RESET;
            r_out_valid <= 1'b0;
            r_row       <= '0;
            r_upd_found <= 1'b0;
            r_h1_found  <= 1'b0;
            r_h2_found  <= 1'b0;
            for (int i = 0; i < TBL_ROWS; i++) begin
                r_valid[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= w_issue;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_mem_limit;
            end
            if (w_pop) begin
                r_row       <= '0;
                r_upd_found <= 1'b0;
                r_h1_found  <= 1'b0;
                r_h2_found  <= 1'b0;
            end else begin
                if (w_issue) begin
                    r_row <= r_row + 1'b1;
                end
                r_upd_found <= n_upd_found;
                r_h1_found  <= n_h1_found;
                r_h2_found  <= n_h2_found;
            end
            if (w_apply && r_job.upd) begin
                r_valid[w_wrow][w_wlane] <= 1'b1;
            end
            if (w_apply && w_ins) begin
                r_ins_pos <= (r_ins_pos == SLOT_LAST) ? '0 : r_ins_pos + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_prefetch_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_job <= i_job;
        end
        r_cmp_row   <= w_rrow;
        r_upd_slot  <= n_upd_slot;
        r_h1_slot   <= n_h1_slot;
        r_h1_stride <= n_h1_stride;
        r_h2_stride <= n_h2_stride;
        if (w_apply) begin
            r_hit        <= n_hit;
            r_hit_stride <= n_hit_stride;
        end
        if (w_load) begin
            r_out_addr <= w_target[ADDR_BITS-1:0];
        end
    end

    assign o_prefetch_valid = r_out_valid;
    assign o_prefetch_addr  = r_out_addr;

    `WPSP_ASSERT_IMP(a_we_in_apply, i_clk, i_rst_n, |w_we, r_state == BK_APPLY, "table written outside apply")
    `WPSP_ASSERT_IMP(a_we_onehot, i_clk, i_rst_n, 1'b1, $onehot0(w_we), "more than one lane written")
    `WPSP_ASSERT_IMP(a_scan_complete, i_clk, i_rst_n, r_state == BK_APPLY, r_row == ROW_END, "apply before full table scan")
    `WPSP_ASSERT_NEXT(a_pop_clears, i_clk, i_rst_n, w_pop, (r_row == '0) && !r_h1_found && !r_upd_found, "search state not cleared on new job")

endmodule

`default_nettype wire

// ----- rtl/windowed_pc_stride_prefetcher_unit.sv -----
// top level of the windowed pc stride prefetcher
// depends on wpsp_pkg, wpsp_front, wpsp_fifo, wpsp_back
//
// channel     direction  signals
// access      in         i_access_valid / o_access_ready, i_access_pc, i_access_addr
// prefetch    out        o_prefetch_valid / i_prefetch_ready, o_prefetch_addr
// cfg         in         i_cfg_valid / o_cfg_ready, i_cfg_mem_limit
//
// front end takes one access a cycle while the two-entry job queue has room
// table engine: dequeue, scan over TBL_ROWS rows, update and check steps per access,
// no new job until the check is done; one read port per lane memory, eight entries a cycle
// no clearing pass after reset: per-entry valid bits clear at once
// a stalled prefetch output holds the engine in its check step only
`default_nettype none

module windowed_pc_stride_prefetcher_unit
    import wpsp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_access_valid,
    output logic                       o_access_ready,
    input  wire logic [PC_BITS-1:0]    i_access_pc,
    input  wire logic [ADDR_BITS-1:0]  i_access_addr,
    output logic                       o_prefetch_valid,
    input  wire logic                  i_prefetch_ready,
    output logic [ADDR_BITS-1:0]       o_prefetch_addr,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [LIMIT_BITS-1:0] i_cfg_mem_limit
);

    logic w_push_valid;
    logic w_push_ready;
    t_job w_push_job;
    logic w_pop_valid;
    logic w_pop_ready;
    t_job w_pop_job;

    assign o_cfg_ready = 1'b1;

    wpsp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_access_valid (i_access_valid),
        .o_access_ready (o_access_ready),
        .i_access_pc    (i_access_pc),
        .i_access_addr  (i_access_addr),
        .o_job_valid    (w_push_valid),
        .i_job_ready    (w_push_ready),
        .o_job          (w_push_job)
    );

    wpsp_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_job   (w_push_job),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_job    (w_pop_job)
    );

    wpsp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_valid      (w_pop_valid),
        .o_job_ready      (w_pop_ready),
        .i_job            (w_pop_job),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_mem_limit  (i_cfg_mem_limit),
        .o_prefetch_valid (o_prefetch_valid),
        .i_prefetch_ready (i_prefetch_ready),
        .o_prefetch_addr  (o_prefetch_addr)
    );

endmodule

`default_nettype wire

// ----- bench/windowed_pc_stride_prefetcher_unit_tb.sv -----
// self-checking bench for windowed_pc_stride_prefetcher_unit: access stream in, prefetches out
// depends on wpsp_pkg and the prefetcher rtl; a scoreboard class predicts each prefetch
`timescale 1ns / 1ps

module windowed_pc_stride_prefetcher_unit_tb;
    import wpsp_pkg::*;

    localparam int DRAIN_CYCLES = 200;

    typedef enum int {
        RX_STEADY,
        RX_COIN,
        RX_SPARSE,
        RX_CHOKE
    } t_stall_mode;

    class stride_prefetch_scoreboard;
        logic [PC_BITS-1:0]            win_pc [WINDOW_DEPTH];
        logic [ADDR_BITS-1:0]          win_addr [WINDOW_DEPTH];
        int                            win_pos;
        bit                            win_full;
        logic [PC_BITS-1:0]            tbl_pc [TABLE_DEPTH];
        logic signed [STRIDE_BITS-1:0] tbl_stride [TABLE_DEPTH];
        int                            ins_pos;
        logic [LIMIT_BITS-1:0]         limit_reg;
        logic [ADDR_BITS-1:0]          pending_prefetches [$];
        int errors, n_access, n_checked, n_negative, n_blocked, n_limits;

        function new();
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                win_pc[i] = '0;
                win_addr[i] = '0;
            end
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                tbl_pc[i] = '0;
                tbl_stride[i] = '0;
            end
            win_pos = 0;
            win_full = 1'b0;
            ins_pos = 0;
            limit_reg = MEM_LIMIT_RESET;
            errors = 0;
            n_access = 0;
            n_checked = 0;
            n_negative = 0;
            n_blocked = 0;
            n_limits = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        function int pending();
            return pending_prefetches.size();
        endfunction

        function void set_limit(logic [LIMIT_BITS-1:0] value);
            limit_reg = value;
            n_limits++;
        endfunction

        // lowest matching index wins
        function int find_entry(logic [PC_BITS-1:0] pc);
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (tbl_pc[i] == pc) return i;
            return -1;
        endfunction

        function void note_access(logic [PC_BITS-1:0] pc, logic [ADDR_BITS-1:0] addr);
            logic signed [STRIDE_BITS-1:0] step;
            logic signed [TARGET_BITS-1:0] tgt;
            int slot;
            int hit;
            n_access++;
            if (win_full) begin
                step = $signed({1'b0, addr}) - $signed({1'b0, win_addr[win_pos]});
                slot = find_entry(win_pc[win_pos]);
                if (slot < 0) begin
                    slot = ins_pos;
                    ins_pos = (ins_pos + 1) % TABLE_DEPTH;
                    tbl_pc[slot] = win_pc[win_pos];
                end
                tbl_stride[slot] = step;
            end
            win_pc[win_pos] = pc;
            win_addr[win_pos] = addr;
            win_pos = (win_pos + 1) % WINDOW_DEPTH;
            if (win_pos == 0) win_full = 1'b1;
            hit = find_entry(pc);
            if (hit >= 0) begin
                tgt = $signed({2'b00, addr}) + tbl_stride[hit];
                if (tgt < 0)
                    n_negative++;
                else if (tgt[TARGET_BITS-2:0] >= limit_reg || tgt[ADDR_BITS])
                    n_blocked++;
                else
                    pending_prefetches.push_back(tgt[ADDR_BITS-1:0]);
            end
        endfunction

        task check_prefetch(logic [ADDR_BITS-1:0] addr);
            logic [ADDR_BITS-1:0] want;
            if (pending_prefetches.size() == 0) begin
                report($sformatf("prefetch %h with none expected", addr));
                return;
            end
            want = pending_prefetches.pop_front();
            n_checked++;
            if (addr !== want)
                report($sformatf("prefetch_addr %h, expected %h", addr, want));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_access_valid;
    logic                  o_access_ready;
    logic [PC_BITS-1:0]    i_access_pc;
    logic [ADDR_BITS-1:0]  i_access_addr;
    logic                  o_prefetch_valid;
    logic                  i_prefetch_ready = 1'b0;
    logic [ADDR_BITS-1:0]  o_prefetch_addr;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [LIMIT_BITS-1:0] i_cfg_mem_limit;

    stride_prefetch_scoreboard sb = new();

    logic [PC_BITS-1:0] pc_pool [16];
    int                 burst_left = 8;
    t_stall_mode        stall_mode = RX_STEADY;
    int                 mode_left = 0;

    windowed_pc_stride_prefetcher_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_access_valid   (i_access_valid),
        .o_access_ready   (o_access_ready),
        .i_access_pc      (i_access_pc),
        .i_access_addr    (i_access_addr),
        .o_prefetch_valid (o_prefetch_valid),
        .i_prefetch_ready (i_prefetch_ready),
        .o_prefetch_addr  (o_prefetch_addr),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_mem_limit  (i_cfg_mem_limit)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("status: fail");
        $finish;
    end

    // receiver: checks each transaction and stalls in changing patterns
    always @(posedge i_clk) begin
        if (i_rst_n && o_prefetch_valid && i_prefetch_ready)
            sb.check_prefetch(o_prefetch_addr);
        if (mode_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            mode_left <= $urandom_range(24, 160);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            RX_STEADY: i_prefetch_ready <= 1'b1;
            RX_COIN:   i_prefetch_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: i_prefetch_ready <= (mode_left % 4 == 0);
            default:   i_prefetch_ready <= ($urandom_range(0, 23) == 0);
        endcase
    end

    function automatic logic [PC_BITS-1:0] pick_pc();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom;
            default: return pc_pool[$urandom_range(0, 15)];
        endcase
    endfunction

    function automatic logic [ADDR_BITS-1:0] pick_step();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return $urandom;
            2, 3:    return ADDR_BITS'($urandom_range(1, 64) << 2);
            default: return ADDR_BITS'(0) - ADDR_BITS'($urandom_range(1, 64) << 2);
        endcase
    endfunction

    task automatic send_access(input logic [PC_BITS-1:0] pc, input logic [ADDR_BITS-1:0] addr);
        i_access_valid <= 1'b1;
        i_access_pc <= pc;
        i_access_addr <= addr;
        do @(posedge i_clk); while (!o_access_ready);
        sb.note_access(pc, addr);
    endtask

    // bursts of transactions with random gaps between them
    task automatic pace();
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            i_access_valid <= 1'b0;
            repeat (($urandom_range(0, 15) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 10))
                @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
        end
    endtask

    task automatic hold_until_drained();
        i_access_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic settle();
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_mem_limit <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_limit(value);
    endtask

    // mostly looping pcs with steady strides, the rest scattered accesses
    task automatic run_traffic(input int count);
        logic [PC_BITS-1:0]   lap_pc [WINDOW_DEPTH];
        logic [ADDR_BITS-1:0] lap_base [WINDOW_DEPTH];
        logic [ADDR_BITS-1:0] lap_step [WINDOW_DEPTH];
        int sent;
        int span;
        int laps;
        bit held;
        sent = 0;
        held = 1'b0;
        while (sent < count) begin
            if (!held && sent >= count / 2) begin
                hold_until_drained();
                held = 1'b1;
            end
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 3))
                    0:       span = 1;
                    1:       span = 2;
                    2:       span = 5;
                    default: span = 10;
                endcase
                laps = 20 / span + $urandom_range(0, 30 / span);
                for (int k = 0; k < span; k++) begin
                    lap_pc[k] = pick_pc();
                    lap_base[k] = $urandom;
                    lap_step[k] = pick_step();
                end
                for (int l = 0; l < laps && sent < count; l++) begin
                    for (int k = 0; k < span && sent < count; k++) begin
                        send_access(lap_pc[k], lap_base[k] + ADDR_BITS'(l) * lap_step[k]);
                        pace();
                        sent++;
                    end
                end
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    send_access($urandom_range(0, 1) ? pick_pc() : PC_BITS'($urandom), $urandom);
                    pace();
                    sent++;
                end
            end
        end
    endtask

    initial begin
        logic [PC_BITS-1:0]   d_pc [22];
        logic [ADDR_BITS-1:0] d_addr [22];
        d_pc = '{32'h0, 32'hFFFFFFFF, 32'h10, 32'h20, 32'h30, 32'h40, 32'h50, 32'h60,
                 32'h70, 32'h80,
                 32'h0, 32'hFFFFFFFF, 32'h10, 32'h20, 32'h30, 32'h40, 32'h50, 32'h60,
                 32'h70, 32'h80,
                 32'h0, 32'hFFFFFFFF};
        d_addr = '{32'h1000, 32'h0, 32'hFFFFFFFF, 32'h100, 32'h7FFFFFFF, 32'h0,
                   32'h80000000, 32'h55555555, 32'h0, 32'h12345678,
                   32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 32'h80, 32'h80000000, 32'h7FFFFFFF,
                   32'hFFFFFFFF, 32'hAAAAAAAA, 32'h80000000, 32'h12345678,
                   32'h10, 32'hFFFFFFFF};
        i_rst_n <= 1'b0;
        i_access_valid <= 1'b0;
        i_access_pc <= '0;
        i_access_addr <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_mem_limit <= '0;
        for (int i = 0; i < 16; i++) pc_pool[i] = $urandom;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fresh table, pc zero, address extremes, negative and oversized targets
        for (int i = 0; i < 22; i++) begin
            send_access(d_pc[i], d_addr[i]);
            pace();
        end
        run_traffic(250);

        settle();
        write_limit('0);
        run_traffic(100);
        settle();
        write_limit(LIMIT_BITS'(1));
        run_traffic(80);
        settle();
        write_limit({1'b0, 32'($urandom)});
        run_traffic(250);
        settle();
        write_limit(MEM_LIMIT_RESET);
        run_traffic(250);
        settle();
        write_limit({1'b0, 32'($urandom)});
        run_traffic(150);
        settle();

        if (sb.pending() != 0)
            sb.report($sformatf("%0d prefetches never arrived", sb.pending()));
        $display("covered %0d accesses over %0d limit settings, %0d prefetches checked",
                 sb.n_access, sb.n_limits + 1, sb.n_checked);
        $display("suppressed targets: %0d negative, %0d at or above the limit",
                 sb.n_negative, sb.n_blocked);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/wpsp_pkg.sv
rtl/wpsp_ram.sv
rtl/wpsp_front.sv
rtl/wpsp_fifo.sv
rtl/wpsp_back.sv
rtl/windowed_pc_stride_prefetcher_unit.sv
bench/windowed_pc_stride_prefetcher_unit_tb.sv
